// ===== rtl/core/lagged_imaging_correlator_assert.svh =====
// assertion macros for the lagged imaging correlator
// no dependencies; included by the top level
`ifndef LAGGED_IMAGING_CORRELATOR_ASSERT_SVH
`define LAGGED_IMAGING_CORRELATOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LIC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lic_pkg.sv =====
// shared types and constants of the lagged imaging correlator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lic_pkg;
	localparam int MAX_X       = 32;
	localparam int MAX_Y       = 32;
	localparam int MAX_Z       = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int ACC_BITS    = 48;
	localparam int FRAC        = SAMPLE_BITS - 1;
	localparam int XW          = $clog2(MAX_X);
	localparam int YW          = $clog2(MAX_Y);
	localparam int ZW          = $clog2(MAX_Z);
	localparam int AW          = XW + YW + ZW;
	localparam int GRID_N      = MAX_X * MAX_Y * MAX_Z;
	localparam int WAVE_W      = 2 * SAMPLE_BITS;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_LOAD  = 2'd1,
		OP_PASS  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_SAT   = 2'd2;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_P_ADDR,
		ST_P_MUL,
		ST_P_WMUL,
		ST_P_ACC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [5:0] pos_x;
		logic signed [5:0] pos_y;
		logic signed [4:0] pos_z;
		logic signed [15:0] src_re;
		logic signed [15:0] src_im;
		logic signed [15:0] rcv_re;
		logic signed [15:0] rcv_im;
		logic signed [47:0] image_in;
		logic signed [15:0] weight_re;
		logic signed [15:0] weight_im;
	} item_t;

	typedef struct packed {
		logic signed [47:0] image_out;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic wr_wave;
		logic wr_img;
		logic mul_a;
		logic mul_b;
		logic acc_write;
		logic push;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic bad;
		logic empty;
		logic last_point;
		logic clear_last;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/lic_if.sv =====
// handshake channels of the lagged imaging correlator
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface lic_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [5:0]  pos_x;
	logic signed [5:0]  pos_y;
	logic signed [4:0]  pos_z;
	logic signed [15:0] src_re;
	logic signed [15:0] src_im;
	logic signed [15:0] rcv_re;
	logic signed [15:0] rcv_im;
	logic signed [47:0] image_in;
	logic signed [15:0] weight_re;
	logic signed [15:0] weight_im;
	modport source(output valid, opcode, pos_x, pos_y, pos_z, src_re, src_im, rcv_re,
		rcv_im, image_in, weight_re, weight_im, input ready);
	modport sink(input valid, opcode, pos_x, pos_y, pos_z, src_re, src_im, rcv_re,
		rcv_im, image_in, weight_re, weight_im, output ready);
endinterface

interface lic_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] image_out;
	logic [1:0]         status;
	modport source(output valid, image_out, status, input ready);
	modport sink(input valid, image_out, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lic_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lic_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/lic_ctrl.sv =====
// controller state machine of the lagged imaging correlator
// depends on lic_pkg
`timescale 1ns / 1ps
`default_nettype none
module lic_ctrl import lic_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.op)
					OP_PASS: state_d = stat.empty ? ST_DONE : ST_P_ADDR;
					OP_STORE: begin
						cmd.wr_wave = !stat.bad;
						state_d     = ST_DONE;
					end
					OP_LOAD: begin
						cmd.wr_img = !stat.bad;
						state_d    = ST_DONE;
					end
					OP_READ: state_d = ST_RDWAIT;
					default: state_d = ST_DONE;
				endcase
			end
			ST_RDWAIT: state_d = ST_DONE;
			ST_P_ADDR: state_d = ST_P_MUL;
			ST_P_MUL: begin
				cmd.mul_a = 1'b1;
				state_d   = ST_P_WMUL;
			end
			ST_P_WMUL: begin
				cmd.mul_b = 1'b1;
				state_d   = ST_P_ACC;
			end
			ST_P_ACC: begin
				cmd.acc_write = 1'b1;
				state_d       = stat.last_point ? ST_DONE : ST_P_ADDR;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/lic_dp.sv =====
// datapath: config registers, grid stores, point counters, correlate arithmetic
// depends on lic_pkg and lic_ram
`timescale 1ns / 1ps
`default_nettype none
module lic_dp import lic_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire item_t       item,
	output result_t          res,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire cmd_t        cmd,
	output stat_t            stat
);
	localparam int PW = 2 * SAMPLE_BITS;
	localparam int CW = PW + 1;
	localparam int MW = CW + SAMPLE_BITS;
	localparam int DW = MW + 1;

	logic [5:0] size_x_q, size_y_q;
	logic [4:0] size_z_q;
	logic [AW-1:0] clr_cnt_q;
	logic out_valid_q;
	result_t res_q;
	logic sat_q;
	logic sum_ovf;

	op_t op_q;
	logic bad_q, empty_q;
	logic [XW-1:0] x_q, lox_q, hix_q;
	logic [YW-1:0] y_q, loy_q, hiy_q;
	logic [ZW-1:0] z_q, hiz_q;
	logic signed [6:0] hx_q, hy_q, hz_q;
	logic signed [SAMPLE_BITS-1:0] wr_q, wi_q;
	logic [WAVE_W-1:0] src_q, rcv_q;
	logic signed [ACC_BITS-1:0] img_in_q;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [MW-1:0] m_re_s2, m_im_s2;

	// effective sizes
	logic [6:0] nx, ny, nz;
	assign nx = (size_x_q > 6'(MAX_X)) ? 7'(MAX_X) : {1'b0, size_x_q};
	assign ny = (size_y_q > 6'(MAX_Y)) ? 7'(MAX_Y) : {1'b0, size_y_q};
	assign nz = ({1'b0, size_z_q} > 6'(MAX_Z)) ? 7'(MAX_Z) : {2'b0, size_z_q};

	logic signed [6:0] px, py, pz, ax, ay, az, hix, hiy, hiz;
	assign px = 7'(item.pos_x);
	assign py = 7'(item.pos_y);
	assign pz = 7'(item.pos_z);
	assign ax = px[6] ? -px : px;
	assign ay = py[6] ? -py : py;
	assign az = pz[6] ? -pz : pz;
	assign hix = signed'(nx) - ax - 7'sd1;
	assign hiy = signed'(ny) - ay - 7'sd1;
	assign hiz = signed'(nz) - az - 7'sd1;

	logic coord_bad, pass_empty, is_pass;
	assign is_pass = (op_t'(item.opcode) == OP_PASS);
	assign coord_bad = px[6] || py[6] || pz[6] || (unsigned'(px) >= nx) ||
		(unsigned'(py) >= ny) || (unsigned'(pz) >= nz);
	assign pass_empty = ({ax, 1'b0} >= {1'b0, nx}) || ({ay, 1'b0} >= {1'b0, ny}) ||
		({az, 1'b0} >= {1'b0, nz});

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 5'd16;
		end else if (cfg_we) begin
			if (cfg_index == REG_SIZE_X) size_x_q <= cfg_data;
			if (cfg_index == REG_SIZE_Y) size_y_q <= cfg_data;
			if (cfg_index == REG_SIZE_Z) size_z_q <= cfg_data[4:0];
		end
	end

	// addresses
	logic [AW-1:0] p_addr, ps_addr, pr_addr;
	logic [6:0] sx, sy, sz, rx, ry, rz;
	assign sx = 7'(x_q) + hx_q;
	assign sy = 7'(y_q) + hy_q;
	assign sz = 7'(z_q) + hz_q;
	assign rx = 7'(x_q) - hx_q;
	assign ry = 7'(y_q) - hy_q;
	assign rz = 7'(z_q) - hz_q;
	assign p_addr  = {z_q, y_q, x_q};
	assign ps_addr = {sz[ZW-1:0], sy[YW-1:0], sx[XW-1:0]};
	assign pr_addr = {rz[ZW-1:0], ry[YW-1:0], rx[XW-1:0]};

	logic last_x, last_y, last_z;
	assign last_x = (x_q == hix_q);
	assign last_y = (y_q == hiy_q);
	assign last_z = (z_q == hiz_q);

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
		end else begin
			if (cmd.clear) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cmd.accept) sat_q <= 1'b0;
			else if (cmd.acc_write && sum_ovf) sat_q <= 1'b1;
		end
	end

	// item latch and point walk
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= op_t'(item.opcode);
			bad_q    <= !is_pass && coord_bad;
			empty_q  <= pass_empty;
			hx_q     <= px;
			hy_q     <= py;
			hz_q     <= pz;
			lox_q    <= ax[XW-1:0];
			loy_q    <= ay[YW-1:0];
			hix_q    <= hix[XW-1:0];
			hiy_q    <= hiy[YW-1:0];
			hiz_q    <= hiz[ZW-1:0];
			x_q      <= is_pass ? ax[XW-1:0] : px[XW-1:0];
			y_q      <= is_pass ? ay[YW-1:0] : py[YW-1:0];
			z_q      <= is_pass ? az[ZW-1:0] : pz[ZW-1:0];
			wr_q     <= item.weight_re;
			wi_q     <= item.weight_im;
			src_q    <= {item.src_re, item.src_im};
			rcv_q    <= {item.rcv_re, item.rcv_im};
			img_in_q <= item.image_in;
		end else if (cmd.acc_write) begin
			if (!last_x) begin
				x_q <= x_q + 1'b1;
			end else begin
				x_q <= lox_q;
				if (!last_y) begin
					y_q <= y_q + 1'b1;
				end else begin
					y_q <= loy_q;
					z_q <= z_q + 1'b1;
				end
			end
		end
	end

	// stores
	logic [WAVE_W-1:0] src_dout, rcv_dout;
	logic [ACC_BITS-1:0] img_dout;
	logic wave_we, img_we;
	logic [AW-1:0] w_addr;
	logic signed [ACC_BITS-1:0] sum_sat;
	logic [ACC_BITS-1:0] img_wdata;

	assign wave_we   = cmd.clear || cmd.wr_wave;
	assign img_we    = cmd.clear || cmd.wr_img || cmd.acc_write;
	assign w_addr    = cmd.clear ? clr_cnt_q : p_addr;
	assign img_wdata = cmd.clear ? '0 : (cmd.wr_img ? img_in_q : sum_sat);

	lic_ram #(.WIDTH(WAVE_W), .DEPTH(GRID_N)) u_src_ram (
		.clk(clk), .we(wave_we), .waddr(w_addr), .wdata(cmd.clear ? '0 : src_q),
		.raddr(ps_addr), .rdata(src_dout)
	);
	lic_ram #(.WIDTH(WAVE_W), .DEPTH(GRID_N)) u_rcv_ram (
		.clk(clk), .we(wave_we), .waddr(w_addr), .wdata(cmd.clear ? '0 : rcv_q),
		.raddr(pr_addr), .rdata(rcv_dout)
	);
	lic_ram #(.WIDTH(ACC_BITS), .DEPTH(GRID_N)) u_img_ram (
		.clk(clk), .we(img_we), .waddr(w_addr), .wdata(img_wdata),
		.raddr(p_addr), .rdata(img_dout)
	);

	// correlate arithmetic: conj(s)*r, then times weight, then round and accumulate
	logic signed [SAMPLE_BITS-1:0] sr, si, rr, ri;
	assign sr = src_dout[WAVE_W-1:SAMPLE_BITS];
	assign si = src_dout[SAMPLE_BITS-1:0];
	assign rr = rcv_dout[WAVE_W-1:SAMPLE_BITS];
	assign ri = rcv_dout[SAMPLE_BITS-1:0];

	logic signed [CW-1:0] c_re, c_im;
	assign c_re = CW'(p_rr_s1) + CW'(p_ii_s1);
	assign c_im = CW'(p_ri_s1) - CW'(p_ir_s1);

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			p_rr_s1 <= sr * rr;
			p_ii_s1 <= si * ri;
			p_ri_s1 <= sr * ri;
			p_ir_s1 <= si * rr;
		end
		if (cmd.mul_b) begin
			m_re_s2 <= MW'(c_re * wr_q);
			m_im_s2 <= MW'(c_im * wi_q);
		end
	end

	logic signed [DW-1:0] d_sum;
	logic signed [ACC_BITS:0] term, sum;
	assign d_sum = DW'(m_re_s2) - DW'(m_im_s2) + DW'(1 << (FRAC - 1));
	assign term  = (ACC_BITS + 1)'(d_sum >>> FRAC);
	assign sum   = (ACC_BITS + 1)'(signed'(img_dout)) + term;
	assign sum_ovf = (sum[ACC_BITS] != sum[ACC_BITS-1]);
	always_comb begin
		if (!sum_ovf) sum_sat = sum[ACC_BITS-1:0];
		else if (sum[ACC_BITS]) sum_sat = {1'b1, {(ACC_BITS - 1){1'b0}}};
		else sum_sat = {1'b0, {(ACC_BITS - 1){1'b1}}};
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_q.image_out <= (op_q == OP_READ && !bad_q) ? img_dout : '0;
			if (bad_q) res_q.status <= STAT_RANGE;
			else if (op_q == OP_PASS && sat_q) res_q.status <= STAT_SAT;
			else res_q.status <= STAT_OK;
		end
	end

	assign res       = res_q;
	assign out_valid = out_valid_q;

	assign stat.op         = op_q;
	assign stat.bad        = bad_q;
	assign stat.empty      = empty_q;
	assign stat.last_point = last_x && last_y && last_z;
	assign stat.clear_last = &clr_cnt_q;
	assign stat.out_free   = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ===== rtl/core/lagged_imaging_correlator.sv =====
// lagged imaging correlator: top level joining controller and datapath
// depends on lic_pkg, lic_if, lic_ctrl, lic_dp and the assertion header
//
// use:
// - in_ch carries one item: an opcode (store wavefield pair, load image,
//   correlate pass, read image), a coordinate or lag, samples and weight
// - out_ch returns exactly one result item for every input item: the image
//   value for a read (else zero) and a status code
// - cfg_we / cfg_index / cfg_data write the size registers; write only idle
// sequencing:
// - store, load: execute, then result; read: execute, read wait, then result
// - correlate pass: the shared multiplier chain and the single read port of
//   each grid memory visit one interior point at a time, stepping through
//   address, multiply, weight multiply and accumulate; at most 16384 points
// - one item at a time: in_ch.ready is high only while nothing is in work
// reset:
// - after arst_n releases, a clearing pass zeroes all three grids, one
//   entry a cycle over all 16384 entries, with in_ch.ready low; config is taken
// stall:
// - a result waits in the output register while out_ch.ready is low, and
//   the next item may already be accepted; its result then waits behind it
`timescale 1ns / 1ps
`default_nettype none
`include "lagged_imaging_correlator_assert.svh"
module lagged_imaging_correlator import lic_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	lic_in_if.sink          in_ch,
	lic_out_if.source       out_ch
);
	item_t   item;
	result_t res;
	cmd_t    cmd;
	stat_t   stat;
	logic    in_ready;
	logic    out_valid;

	// pack the incoming item
	assign item.opcode    = in_ch.opcode;
	assign item.pos_x     = in_ch.pos_x;
	assign item.pos_y     = in_ch.pos_y;
	assign item.pos_z     = in_ch.pos_z;
	assign item.src_re    = in_ch.src_re;
	assign item.src_im    = in_ch.src_im;
	assign item.rcv_re    = in_ch.rcv_re;
	assign item.rcv_im    = in_ch.rcv_im;
	assign item.image_in  = in_ch.image_in;
	assign item.weight_re = in_ch.weight_re;
	assign item.weight_im = in_ch.weight_im;

	assign in_ch.ready      = in_ready;
	assign out_ch.valid     = out_valid;
	assign out_ch.image_out = res.image_out;
	assign out_ch.status    = res.status;

	// sequencer: clear sweep, item dispatch, per-point steps of a pass
	lic_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.stat(stat),
		.cmd(cmd)
	);

	// grids, counters, multiplier chain, result register
	lic_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item),
		.res(res),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.cmd(cmd),
		.stat(stat)
	);

	// an accepted item keeps the block busy for at least the next cycle
	`LIC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_ch.valid && in_ready, !in_ready, "item accepted while busy")
	// a new result never overwrites one still waiting
	`LIC_ASSERT_IMP(a_no_result_overwrite, clk, arst_n, cmd.push, !out_valid || out_ch.ready, "result overwritten")
	// no accumulate write or clearing write while the input side is open
	`LIC_ASSERT_IMP(a_pass_closed, clk, arst_n, cmd.acc_write || cmd.clear, !in_ready, "accept during pass or clear")
endmodule
`default_nettype wire

// ===== test/lic_image_checker.sv =====
// checker for the lagged imaging correlator: keeps its own copy of the three grids,
// predicts one result per accepted item and compares the result channel against it
// depends on lic_pkg and the channel interfaces of lic_if
`timescale 1ns / 1ps
`default_nettype none
module lic_image_checker import lic_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	lic_in_if               in_ch,
	lic_out_if              out_ch,
	output int              fails,
	output int              pending
);
	localparam longint IMG_MAX = (64'sd1 <<< (ACC_BITS - 1)) - 1;
	localparam longint IMG_MIN = -IMG_MAX - 1;

	logic signed [15:0] src_re[GRID_N];
	logic signed [15:0] src_im[GRID_N];
	logic signed [15:0] rcv_re[GRID_N];
	logic signed [15:0] rcv_im[GRID_N];
	longint             image[GRID_N];
	logic [5:0]         size_x = 6'd32;
	logic [5:0]         size_y = 6'd32;
	logic [4:0]         size_z = 5'd16;
	result_t            pending_results[$];

	initial begin
		fails = 0;
		pending = 0;
		for (int i = 0; i < GRID_N; i++) begin
			src_re[i] = '0;
			src_im[i] = '0;
			rcv_re[i] = '0;
			rcv_im[i] = '0;
			image[i] = 0;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	function automatic int grid_index(input int x, input int y, input int z);
		return (z * MAX_Y + y) * MAX_X + x;
	endfunction

	// one correlation pass over the interior; returns 1 if any add clamped
	function automatic bit correlate(input int hx, input int hy, input int hz,
			input longint wr, input longint wi);
		int nx, ny, nz, ax, ay, az, ps, pr, p;
		longint sr, si, rr, ri, cr, ci, term, sum;
		bit clamped;
		clamped = 0;
		nx = size_x < MAX_X ? int'(size_x) : MAX_X;
		ny = size_y < MAX_Y ? int'(size_y) : MAX_Y;
		nz = size_z < MAX_Z ? int'(size_z) : MAX_Z;
		ax = hx < 0 ? -hx : hx;
		ay = hy < 0 ? -hy : hy;
		az = hz < 0 ? -hz : hz;
		for (int z = az; z < nz - az; z++)
			for (int y = ay; y < ny - ay; y++)
				for (int x = ax; x < nx - ax; x++) begin
					ps = grid_index(x + hx, y + hy, z + hz);
					pr = grid_index(x - hx, y - hy, z - hz);
					p = grid_index(x, y, z);
					sr = src_re[ps];
					si = src_im[ps];
					rr = rcv_re[pr];
					ri = rcv_im[pr];
					// conj(s) * r, then real part of the weighted product, rounded
					cr = sr * rr + si * ri;
					ci = sr * ri - si * rr;
					term = (cr * wr - ci * wi + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
					sum = image[p] + term;
					if (sum > IMG_MAX) begin
						sum = IMG_MAX;
						clamped = 1;
					end else if (sum < IMG_MIN) begin
						sum = IMG_MIN;
						clamped = 1;
					end
					image[p] = sum;
				end
		return clamped;
	endfunction

	function automatic result_t predict_result(input item_t it);
		result_t r;
		int px, py, pz, p;
		r = '0;
		px = it.pos_x;
		py = it.pos_y;
		pz = it.pos_z;
		if (it.opcode == OP_PASS) begin
			if (correlate(px, py, pz, longint'(it.weight_re), longint'(it.weight_im)))
				r.status = STAT_SAT;
		end else if (px < 0 || py < 0 || pz < 0 || px >= int'(size_x) || px >= MAX_X ||
				py >= int'(size_y) || py >= MAX_Y || pz >= int'(size_z) || pz >= MAX_Z) begin
			r.status = STAT_RANGE;
		end else begin
			p = grid_index(px, py, pz);
			case (it.opcode)
				OP_STORE: begin
					src_re[p] = it.src_re;
					src_im[p] = it.src_im;
					rcv_re[p] = it.rcv_re;
					rcv_im[p] = it.rcv_im;
				end
				OP_LOAD: image[p] = longint'(it.image_in);
				default: r.image_out = image[p][47:0];
			endcase
		end
		return r;
	endfunction

	always @(posedge clk) begin
		item_t   it;
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result item", $realtime);
				fails++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.image_out !== want.image_out)
					report("image_out", out_ch.image_out, want.image_out);
				if (out_ch.status !== want.status)
					report("status", out_ch.status, want.status);
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			it.opcode = in_ch.opcode;
			it.pos_x = in_ch.pos_x;
			it.pos_y = in_ch.pos_y;
			it.pos_z = in_ch.pos_z;
			it.src_re = in_ch.src_re;
			it.src_im = in_ch.src_im;
			it.rcv_re = in_ch.rcv_re;
			it.rcv_im = in_ch.rcv_im;
			it.image_in = in_ch.image_in;
			it.weight_re = in_ch.weight_re;
			it.weight_im = in_ch.weight_im;
			pending_results.push_back(predict_result(it));
		end
		if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: size_x = cfg_data;
				REG_SIZE_Y: size_y = cfg_data;
				REG_SIZE_Z: size_z = cfg_data[4:0];
				default: ;
			endcase
		end
		pending = pending_results.size();
	end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench top for the lagged imaging correlator: clock, reset, stimulus and verdict
// depends on lic_pkg, lic_if, the block itself and lic_image_checker
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import lic_pkg::*;

	localparam int STALL_LIMIT = 250000; // clearing pass plus one full-grid pass, several times

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;
	logic       calm;     // no idling on either side while set
	int         fails;
	int         pending;
	int         quiet_cycles;

	lic_in_if  in_ch();
	lic_out_if out_ch();

	lagged_imaging_correlator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	lic_image_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls about 6 percent of the time, unless calm is set
	always @(negedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 6);
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** lagged_imaging_correlator: FAILED **");
			$finish;
		end
	end

	// random payload in every field, position and opcode given
	function automatic item_t make_item(input op_t op, input int x, input int y, input int z);
		item_t it;
		it.opcode = op;
		it.pos_x = 6'(x);
		it.pos_y = 6'(y);
		it.pos_z = 5'(z);
		it.src_re = 16'($urandom);
		it.src_im = 16'($urandom);
		it.rcv_re = 16'($urandom);
		it.rcv_im = 16'($urandom);
		it.image_in = 48'({$urandom, $urandom});
		it.weight_re = 16'($urandom);
		it.weight_im = 16'($urandom);
		return it;
	endfunction

	// hand one item over; returns at the falling edge after acceptance
	task automatic send(input item_t it);
		while (!calm && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.opcode <= it.opcode;
		in_ch.pos_x <= it.pos_x;
		in_ch.pos_y <= it.pos_y;
		in_ch.pos_z <= it.pos_z;
		in_ch.src_re <= it.src_re;
		in_ch.src_im <= it.src_im;
		in_ch.rcv_re <= it.rcv_re;
		in_ch.rcv_im <= it.rcv_im;
		in_ch.image_in <= it.image_in;
		in_ch.weight_re <= it.weight_re;
		in_ch.weight_im <= it.weight_im;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// stop sending and wait until every result is back, plus the block's tail
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [5:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_sizes(input int sx, input int sy, input int sz);
		drain();
		write_reg(REG_SIZE_X, 6'(sx));
		write_reg(REG_SIZE_Y, 6'(sy));
		write_reg(REG_SIZE_Z, 6'(sz));
	endtask

	// mostly well-formed traffic inside the grid, a little noise
	task automatic random_phase(input int nx, input int ny, input int nz, input int count);
		item_t it;
		int pick;
		set_sizes(nx, ny, nz);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// noise: any bit pattern in every field
				it = make_item(op_t'($urandom_range(3)), 0, 0, 0);
				it.pos_x = 6'($urandom);
				it.pos_y = 6'($urandom);
				it.pos_z = 5'($urandom);
			end else if (pick < 14) begin
				// just past the edge of the grid
				it = make_item(op_t'($urandom_range(1) ? OP_STORE : OP_READ),
					$urandom_range(1) ? nx : $urandom_range(nx - 1),
					$urandom_range(1) ? ny : $urandom_range(ny - 1), nz);
			end else if (pick < 44) begin
				it = make_item(OP_STORE, $urandom_range(nx - 1), $urandom_range(ny - 1),
					$urandom_range(nz - 1));
			end else if (pick < 52) begin
				it = make_item(OP_LOAD, $urandom_range(nx - 1), $urandom_range(ny - 1),
					$urandom_range(nz - 1));
				// mostly modest images, sometimes near the accumulator limits
				if ($urandom_range(3) != 0)
					it.image_in = $signed(it.image_in) >>> 16;
			end else if (pick < 64) begin
				// lags that leave some interior, most of the time
				it = make_item(OP_PASS, int'($urandom_range(nx / 2)) - int'($urandom_range(nx / 2)),
					int'($urandom_range(ny / 2)) - int'($urandom_range(ny / 2)),
					int'($urandom_range(nz / 2)) - int'($urandom_range(nz / 2)));
			end else begin
				it = make_item(OP_READ, $urandom_range(nx - 1), $urandom_range(ny - 1),
					$urandom_range(nz - 1));
			end
			send(it);
		end
	endtask

	initial begin
		item_t it;
		calm = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet_cycles = 0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.src_re = '0;
		in_ch.src_im = '0;
		in_ch.rcv_re = '0;
		in_ch.rcv_im = '0;
		in_ch.image_in = '0;
		in_ch.weight_re = '0;
		in_ch.weight_im = '0;
		out_ch.ready = 1'b1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single point grid: saturation both ways and the sample extremes
		set_sizes(1, 1, 1);
		it = make_item(OP_STORE, 0, 0, 0);
		it.src_re = -16'sd32768; it.src_im = '0;
		it.rcv_re = -16'sd32768; it.rcv_im = '0;
		send(it);
		it = make_item(OP_LOAD, 0, 0, 0);
		it.image_in = 48'sh7fff_ffff_ffff;
		send(it);
		it = make_item(OP_PASS, 0, 0, 0);
		it.weight_re = 16'sd32767; it.weight_im = '0;
		send(it); // positive clamp
		send(make_item(OP_READ, 0, 0, 0));
		it = make_item(OP_LOAD, 0, 0, 0);
		it.image_in = 48'sh8000_0000_0000;
		send(it);
		it = make_item(OP_PASS, 0, 0, 0);
		it.weight_re = -16'sd32768; it.weight_im = '0;
		send(it); // negative clamp
		send(make_item(OP_READ, 0, 0, 0));
		it = make_item(OP_STORE, 0, 0, 0);
		it.src_re = 16'sd32767; it.src_im = -16'sd32768;
		it.rcv_re = -16'sd32768; it.rcv_im = 16'sd32767;
		send(it);
		it = make_item(OP_LOAD, 0, 0, 0);
		it.image_in = '0;
		send(it);
		it = make_item(OP_PASS, 0, 0, 0);
		it.weight_re = 16'sd32767; it.weight_im = -16'sd32768;
		send(it); // phase weight, lag zero
		send(make_item(OP_READ, 0, 0, 0));
		send(make_item(OP_PASS, 1, 0, 0));        // empty pass
		send(make_item(OP_PASS, -31, -31, -15));  // empty pass, lag extremes
		// coordinates out of range
		send(make_item(OP_STORE, 1, 0, 0));
		send(make_item(OP_READ, -1, 0, 0));
		send(make_item(OP_LOAD, 0, 31, 0));
		send(make_item(OP_READ, 0, 0, -15));
		send(make_item(OP_STORE, 31, 31, 15));

		// size registers zero: nothing is in range, passes are empty
		set_sizes(0, 0, 0);
		write_reg(2'd3, 6'h2a); // unknown register index, ignored
		send(make_item(OP_READ, 0, 0, 0));
		send(make_item(OP_PASS, 0, 0, 0));
		send(make_item(OP_STORE, 0, 0, 0));

		// register values above the grid clip to the full grid
		set_sizes(63, 63, 31);
		send(make_item(OP_STORE, 31, 31, 15));
		send(make_item(OP_READ, 31, 31, 15));
		send(make_item(OP_PASS, 15, 15, 7));
		send(make_item(OP_PASS, 0, 0, 0)); // full grid pass
		send(make_item(OP_READ, 31, 31, 15));

		// random traffic on small grids, one phase with no idling at all
		random_phase(4, 3, 2, 15);
		calm = 1'b1;
		random_phase(5, 2, 3, 20);
		calm = 1'b0;
		random_phase(2, 6, 1, 15);
		random_phase(3, 3, 3, 15);
		random_phase(32, 1, 1, 10);

		drain();
		if (fails == 0)
			$display("** lagged_imaging_correlator: PASSED **");
		else
			$display("** lagged_imaging_correlator: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
